// ----- rtl/i4p_pkg.sv -----
package i4p_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int EDGE_LEN    = 13;
    localparam int CORNER_POS  = 4;

    localparam logic [3:0] M_VERT = 4'd0;
    localparam logic [3:0] M_HORZ = 4'd1;
    localparam logic [3:0] M_DC   = 4'd2;
    localparam logic [3:0] M_DDL  = 4'd3;
    localparam logic [3:0] M_DDR  = 4'd4;
    localparam logic [3:0] M_VR   = 4'd5;
    localparam logic [3:0] M_HD   = 4'd6;
    localparam logic [3:0] M_VL   = 4'd7;
    localparam logic [3:0] M_HU   = 4'd8;

    localparam logic [1:0] K_EDGE = 2'd0;
    localparam logic [1:0] K_F2   = 2'd1;
    localparam logic [1:0] K_F3   = 2'd2;
    localparam logic [1:0] K_DC   = 2'd3;

    localparam logic [1:0] LAST_ROW = 2'd3;

    typedef logic [SAMPLE_BITS-1:0] t_smp;

    // edge[0..3] = left y=3..0, edge[4] = corner, edge[5..12] = above x=0..7
    typedef t_smp [EDGE_LEN-1:0] t_edge;

    typedef struct packed {
        logic [3:0] mode;
        logic       ok;
        t_smp       dc;
        t_edge      edge_smp;
    } t_job;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] idx;
    } t_pick;

    function automatic t_smp avg2(input t_smp a, input t_smp b);
        logic [SAMPLE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b} + (SAMPLE_BITS+1)'(1);
        return s[SAMPLE_BITS:1];
    endfunction

    function automatic t_smp avg3(input t_smp a, input t_smp b, input t_smp c);
        logic [SAMPLE_BITS+1:0] s;
        s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + (SAMPLE_BITS+2)'(2);
        return s[SAMPLE_BITS+1:2];
    endfunction

    // source of sample (x, y) for a mode, as an index into the edge or its filtered forms
    function automatic t_pick pick(input logic [3:0] mode, input logic [1:0] x,
                                   input logic [1:0] y);
        int xi;
        int yi;
        int z;
        int b;
        int idx;
        logic [1:0] kind;
        t_pick p;
        xi   = int'(x);
        yi   = int'(y);
        z    = 0;
        b    = 0;
        idx  = 0;
        kind = K_DC;
        case (mode)
            M_VERT: begin
                kind = K_EDGE;
                idx  = 5 + xi;
            end
            M_HORZ: begin
                kind = K_EDGE;
                idx  = 3 - yi;
            end
            M_DC: begin
                kind = K_DC;
            end
            M_DDL: begin
                kind = K_F3;
                idx  = 6 + xi + yi;
            end
            M_DDR: begin
                kind = K_F3;
                idx  = 4 + xi - yi;
            end
            M_VR: begin
                z = 2 * xi - yi;
                if (z >= 0) begin
                    b = xi - (yi >> 1);
                    kind = ((z & 1) == 0) ? K_F2 : K_F3;
                    idx  = 4 + b;
                end else if (z == -1) begin
                    kind = K_F3;
                    idx  = 4;
                end else begin
                    kind = K_F3;
                    idx  = 5 - yi;
                end
            end
            M_HD: begin
                z = 2 * yi - xi;
                if (z >= 0) begin
                    b = yi - (xi >> 1);
                    if ((z & 1) == 0) begin
                        kind = K_F2;
                        idx  = 3 - b;
                    end else begin
                        kind = K_F3;
                        idx  = 4 - b;
                    end
                end else if (z == -1) begin
                    kind = K_F3;
                    idx  = 4;
                end else begin
                    kind = K_F3;
                    idx  = 3 + xi;
                end
            end
            M_VL: begin
                b = xi + (yi >> 1);
                if ((yi & 1) == 0) begin
                    kind = K_F2;
                    idx  = 5 + b;
                end else begin
                    kind = K_F3;
                    idx  = 6 + b;
                end
            end
            M_HU: begin
                z = xi + 2 * yi;
                b = yi + (xi >> 1);
                if (z < 5 && (z & 1) == 0) begin
                    kind = K_F2;
                    idx  = 2 - b;
                end else if (z == 1 || z == 3) begin
                    kind = K_F3;
                    idx  = 2 - b;
                end else if (z == 5) begin
                    kind = K_F3;
                    idx  = 0;
                end else begin
                    kind = K_EDGE;
                    idx  = 0;
                end
            end
            default: begin
                kind = K_DC;
            end
        endcase
        p.kind = kind;
        p.idx  = 4'(idx);
        return p;
    endfunction

endpackage

// ----- rtl/i4p_if.sv -----
interface i4p_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic [63:0] top_row;
    logic [31:0] left_col;
    logic [7:0]  corner;
    logic        left_avail;
    logic        up_left_avail;
    logic        up_avail;
    logic        up_right_avail;

    modport source (
        output valid, func, top_row, left_col, corner,
               left_avail, up_left_avail, up_avail, up_right_avail,
        input  ready
    );
    modport sink (
        input  valid, func, top_row, left_col, corner,
               left_avail, up_left_avail, up_avail, up_right_avail,
        output ready
    );
endinterface

interface i4p_row_if;
    logic        valid;
    logic        ready;
    logic [1:0]  row_index;
    logic [31:0] row_samples;
    logic        last;

    modport source (
        output valid, row_index, row_samples, last,
        input  ready
    );
    modport sink (
        input  valid, row_index, row_samples, last,
        output ready
    );
endinterface

// ----- rtl/i4p_front.sv -----
module i4p_front (
    i4p_req_if.sink       i_req,
    input  logic          i_full,
    output logic          o_push,
    output i4p_pkg::t_job o_job
);

    logic                 ura_eff;
    logic [9:0]           sum_h;
    logic [9:0]           sum_v;
    logic [10:0]          sum_hv;
    i4p_pkg::t_edge       edge_smp;
    i4p_pkg::t_smp        dc;
    logic                 ok;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;
    assign ura_eff     = i_req.up_right_avail || i_req.up_avail;

    always_comb begin
        edge_smp = '0;
        edge_smp[i4p_pkg::CORNER_POS] = i_req.corner;
        for (int i = 0; i < 8; i++) begin
            if (i >= 4 && i_req.up_avail && !i_req.up_right_avail) begin
                edge_smp[i4p_pkg::CORNER_POS + 1 + i] = i_req.top_row[31:24];
            end else begin
                edge_smp[i4p_pkg::CORNER_POS + 1 + i] = i_req.top_row[8*i +: 8];
            end
        end
        for (int j = 0; j < 4; j++) begin
            edge_smp[i4p_pkg::CORNER_POS - 1 - j] = i_req.left_col[8*j +: 8];
        end
    end

    always_comb begin
        sum_h = 10'(i_req.top_row[7:0]) + 10'(i_req.top_row[15:8])
              + 10'(i_req.top_row[23:16]) + 10'(i_req.top_row[31:24]);
        sum_v = 10'(i_req.left_col[7:0]) + 10'(i_req.left_col[15:8])
              + 10'(i_req.left_col[23:16]) + 10'(i_req.left_col[31:24]);
        sum_hv = 11'(sum_h) + 11'(sum_v) + 11'd4;
        if (i_req.left_avail && i_req.up_avail) begin
            dc = sum_hv[10:3];
        end else if (i_req.left_avail) begin
            dc = 8'((sum_v + 10'd2) >> 2);
        end else if (i_req.up_avail) begin
            dc = 8'((sum_h + 10'd2) >> 2);
        end else begin
            dc = i4p_pkg::t_smp'(1 << (i4p_pkg::SAMPLE_BITS - 1));
        end
    end

    always_comb begin
        case (i_req.func)
            i4p_pkg::M_VERT: ok = i_req.up_avail;
            i4p_pkg::M_HORZ: ok = i_req.left_avail;
            i4p_pkg::M_DC:   ok = 1'b1;
            i4p_pkg::M_DDL,
            i4p_pkg::M_VL:   ok = i_req.up_avail && ura_eff;
            i4p_pkg::M_DDR,
            i4p_pkg::M_VR,
            i4p_pkg::M_HD:   ok = i_req.up_avail && i_req.up_left_avail && i_req.left_avail;
            i4p_pkg::M_HU:   ok = i_req.left_avail;
            default:         ok = 1'b0;
        endcase
    end

    always_comb begin
        o_job.mode     = i_req.func;
        o_job.ok       = ok;
        o_job.dc       = dc;
        o_job.edge_smp = edge_smp;
    end

endmodule

// ----- rtl/i4p_queue.sv -----
module i4p_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  i4p_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output i4p_pkg::t_job o_job,
    input  logic          i_pop
);

    i4p_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          n_wp;
    logic          n_rp;
    logic [1:0]    n_cnt;
    logic          pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wp  = i_push ? !r_wp : r_wp;
        n_rp  = pop ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/i4p_back.sv -----
module i4p_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  i4p_pkg::t_job i_job,
    output logic          o_pop,
    i4p_row_if.source     o_row
);

    logic [1:0]     r_row;
    logic           r_vld;
    logic [1:0]     r_idx;
    logic [31:0]    r_samp;
    logic           r_last;
    logic [1:0]     n_row;
    logic           advance;
    i4p_pkg::t_smp  f2 [12];
    i4p_pkg::t_smp  f3 [13];
    logic [31:0]    row_samp;
    i4p_pkg::t_pick pk [4];

    assign advance = i_valid && (!r_vld || o_row.ready);
    assign o_pop   = advance && (r_row == i4p_pkg::LAST_ROW);
    assign n_row   = advance ? r_row + 2'd1 : r_row;

    always_comb begin
        for (int k = 0; k < 12; k++) begin
            f2[k] = i4p_pkg::avg2(i_job.edge_smp[k], i_job.edge_smp[k+1]);
        end
        f3[0]  = i4p_pkg::avg3(i_job.edge_smp[1], i_job.edge_smp[0], i_job.edge_smp[0]);
        for (int k = 1; k < 12; k++) begin
            f3[k] = i4p_pkg::avg3(i_job.edge_smp[k-1], i_job.edge_smp[k],
                                  i_job.edge_smp[k+1]);
        end
        f3[12] = i4p_pkg::avg3(i_job.edge_smp[11], i_job.edge_smp[12], i_job.edge_smp[12]);
    end

    always_comb begin
        row_samp = '0;
        for (int x = 0; x < 4; x++) begin
            pk[x] = i4p_pkg::pick(i_job.mode, 2'(x), r_row);
            case (pk[x].kind)
                i4p_pkg::K_EDGE: row_samp[8*x +: 8] = i_job.edge_smp[pk[x].idx];
                i4p_pkg::K_F2:   row_samp[8*x +: 8] = f2[pk[x].idx];
                i4p_pkg::K_F3:   row_samp[8*x +: 8] = f3[pk[x].idx];
                default:         row_samp[8*x +: 8] = i_job.dc;
            endcase
        end
        if (!i_job.ok) begin
            row_samp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_idx  <= r_row;
            r_samp <= row_samp;
            r_last <= (r_row == i4p_pkg::LAST_ROW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 2'd0;
            r_vld <= 1'b0;
        end else begin
            r_row <= n_row;
            if (advance) begin
                r_vld <= 1'b1;
            end else if (o_row.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    assign o_row.valid       = r_vld;
    assign o_row.row_index   = r_idx;
    assign o_row.row_samples = r_samp;
    assign o_row.last        = r_last;

endmodule

// ----- rtl/h264_intra4x4_luma_predictor_core.sv -----
// channel  dir  modport  payload
// i_req    in   sink     func, top_row, left_col, corner, four availability flags
// o_row    out  source   row_index, row_samples, last
//
// A request is classified (edge padding, DC, availability) as it is taken and
// enters a two-entry queue; the row generator then emits four rows, one per cycle while o_row is not stalled.
// Sustained request throughput is set by the single-row output stage.
// A taken request is written into the queue; its first row is then registered in the output register for o_row.
// i_rst_n is synchronous, active low; it empties the queue and the output register.
// A stalled o_row holds its row; the queue keeps taking requests until full.
module h264_intra4x4_luma_predictor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i4p_req_if.sink     i_req,
    i4p_row_if.source   o_row
);

    logic          push;
    logic          full;
    logic          head_valid;
    logic          pop;
    i4p_pkg::t_job in_job;
    i4p_pkg::t_job head_job;

    i4p_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_job  (in_job)
    );

    i4p_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (in_job),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    i4p_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_row   (o_row)
    );

endmodule
